/* hdl/sorted_binding_table_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted binding table.
// Shared helpers so every module reports failures the same way.
// ----------------------------------------------------------------------------
`ifndef SORTED_BINDING_TABLE_TOP_ASSERT_SVH
`define SORTED_BINDING_TABLE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SBT_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SBT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/sbt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted binding table package
// Shared types, codes and the part classification function.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_CLASSIFY = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADRNG  = 2'd3;

    localparam logic [2:0] PART_NONE      = 3'd0;
    localparam logic [2:0] PART_BUTTON    = 3'd1;
    localparam logic [2:0] PART_AXIS_LOW  = 3'd2;
    localparam logic [2:0] PART_AXIS_HIGH = 3'd3;
    localparam logic [2:0] PART_HAT_N     = 3'd4;
    localparam logic [2:0] PART_HAT_E     = 3'd5;
    localparam logic [2:0] PART_HAT_S     = 3'd6;
    localparam logic [2:0] PART_HAT_W     = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE, S_CLASS, S_PROBE, S_WAIT, S_DECIDE, S_SHIFT, S_WRITE, S_EMIT
    } sbt_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture transaction fields
        logic classify;   // register classification result
        logic srch_init;  // reset search bounds
        logic probe;      // issue memory read at midpoint
        logic compare;    // update bounds from read data
        logic shift;      // move one entry up
        logic write;      // write new entry, bump count
        logic emit;       // drive result strobe
    } sbt_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic bad_range;
        logic srch_done;
        logic hit;
        logic full;
        logic shift_done;
        logic is_lookup;
    } sbt_stat_t;

    // Classification: returns {valid, part}. Sums are done at 34 bits so they
    // stay exact.
    function automatic logic [3:0] classify_part(
        input logic signed [31:0] rlo, input logic signed [31:0] rhi,
        input logic cap, input logic signed [31:0] clo, input logic signed [31:0] chi);
        logic signed [33:0] l, h, cl, ch, half;
        logic is_min, is_max;
        l  = 34'(rlo);
        h  = 34'(rhi);
        cl = 34'(clo);
        ch = 34'(chi);
        half = ch >>> 1;
        is_min = (rlo == 32'sh8000_0000);
        is_max = (rhi == 32'sh7fff_ffff);
        if (l > h) return {1'b1, PART_HAT_N};
        if (!cap) return {1'b1, PART_BUTTON};
        if (cl == 0 && (ch == 1 || ch == 2 || (l < half && !is_min && ch != 7)))
            return {1'b1, PART_BUTTON};
        if (cl == ch - 34'sd7) begin
            if (l == cl + 34'sd1) return {1'b1, PART_HAT_E};
            if (l == cl + 34'sd3) return {1'b1, PART_HAT_S};
            if (l == cl + 34'sd5) return {1'b1, PART_HAT_W};
            return {1'b1, PART_NONE};
        end
        if (is_min) return {1'b1, PART_AXIS_LOW};
        if (is_max) return {1'b1, PART_AXIS_HIGH};
        return {1'b0, PART_NONE};
    endfunction

endpackage

/* hdl/sorted_binding_table_top.sv */
// ----------------------------------------------------------------------------
// Sorted binding table
// Binding table kept sorted by (button id, part) with add, classify and lookup.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  command   start / busy     action, button_id, part, range and cap fields
//  result    done strobe      status, found, position, resolved_part, dest
//
// Each binary search probe (at most ceil(log2(n+1)) probes for n entries)
// is a registered memory read followed by a compare step, and busy stays
// high from the accepting edge through the result step. An insertion moves
// up m entries (up to n) and then writes the new one; the moves are
// pipelined at one entry per cycle. The result strobe comes in the same
// cycle that busy falls, and the next transaction can be accepted at the
// edge that ends it. Reset clears the entry count, the result strobe and
// the controller state; the entry memory needs no clearing pass. The result
// strobe lasts one cycle and cannot be stalled.
module sorted_binding_table_top #(
    parameter int TABLE_ENTRIES = sbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] button_id,
    input  logic [2:0]         part,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic               cap_present,
    input  logic signed [31:0] cap_low,
    input  logic signed [31:0] cap_high,
    input  logic [7:0]         dest_type,
    input  logic [15:0]        dest_button,
    output logic               done,
    output logic [1:0]         status,
    output logic               found,
    output logic [6:0]         position,
    output logic [2:0]         resolved_part,
    output logic [7:0]         out_dest_type,
    output logic [15:0]        out_dest_button
);
    import sbt_pkg::*;

    sbt_cmd_t  cmd;
    sbt_stat_t stat;

    // The controller only steps the sequence; all storage is in the datapath.
    sbt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
    );

    sbt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .action(action), .button_id(button_id), .part(part),
        .range_low(range_low), .range_high(range_high), .cap_present(cap_present),
        .cap_low(cap_low), .cap_high(cap_high), .dest_type(dest_type),
        .dest_button(dest_button), .done(done), .status(status), .found(found),
        .position(position), .resolved_part(resolved_part),
        .out_dest_type(out_dest_type), .out_dest_button(out_dest_button)
    );

endmodule

/* hdl/sbt_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted binding table controller
// Sequences classification, binary search, insertion shift and result.
// ----------------------------------------------------------------------------
module sbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output sbt_pkg::sbt_cmd_t cmd,
    input  sbt_pkg::sbt_stat_t stat
);
    import sbt_pkg::*;

    sbt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                cmd.srch_init = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (stat.bad_range || stat.srch_done)
                    state_next = S_DECIDE;
                else
                begin
                    cmd.probe = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.compare = 1'b1;
                state_next = S_PROBE;
            end
            S_DECIDE:
            begin
                if (stat.bad_range || stat.hit || stat.is_lookup || stat.full)
                    state_next = S_EMIT;
                else
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                    state_next = S_WRITE;
                else
                    cmd.shift = 1'b1;
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* hdl/sbt_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted binding table datapath
// Entry memory, search bounds, shift pointer and result registers.
// ----------------------------------------------------------------------------
module sbt_datapath #(
    parameter int TABLE_ENTRIES = sbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sbt_pkg::sbt_cmd_t  cmd,
    output sbt_pkg::sbt_stat_t stat,
    input  logic [1:0]         action,
    input  logic signed [31:0] button_id,
    input  logic [2:0]         part,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic               cap_present,
    input  logic signed [31:0] cap_low,
    input  logic signed [31:0] cap_high,
    input  logic [7:0]         dest_type,
    input  logic [15:0]        dest_button,
    output logic               done,
    output logic [1:0]         status,
    output logic               found,
    output logic [6:0]         position,
    output logic [2:0]         resolved_part,
    output logic [7:0]         out_dest_type,
    output logic [15:0]        out_dest_button
);
    import sbt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = 32 + 3 + 8 + 16;

    logic [EW-1:0] mem [TABLE_ENTRIES];
    logic [EW-1:0] rd_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, hi_reg, ptr_reg;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [1:0]    act_reg;
    logic signed [31:0] id_reg, rlo_reg, rhi_reg, clo_reg, chi_reg;
    logic          cap_reg;
    logic [2:0]    part_reg;
    logic [7:0]    dt_reg;
    logic [15:0]   db_reg;
    logic          bad_reg, hit_reg;
    logic          shift_pend_reg;
    logic          no_insert_reg;
    logic [3:0]    cls;
    logic signed [31:0] e_id;
    logic [2:0]    e_part;
    logic          key_lt, key_gt;
    logic          do_ins;

    // The bound sum needs one bit more than the bounds themselves.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = mid_sum[CW:1];
    assign cls = classify_part(rlo_reg, rhi_reg, cap_reg, clo_reg, chi_reg);
    assign e_id = rd_reg[EW-1 -: 32];
    assign e_part = rd_reg[26:24];
    assign key_lt = (id_reg < e_id) || (id_reg == e_id && part_reg < e_part);
    assign key_gt = (id_reg > e_id) || (id_reg == e_id && part_reg > e_part);
    assign do_ins = (act_reg == ACT_ADD || act_reg == ACT_CLASSIFY);

    assign stat.bad_range = bad_reg;
    assign stat.srch_done = hit_reg || (lo_reg >= hi_reg);
    assign stat.hit = hit_reg;
    assign stat.full = (count_reg >= CW'(TABLE_ENTRIES));
    assign stat.shift_done = (ptr_reg <= lo_reg);
    assign stat.is_lookup = !do_ins;

    // Memory: one write port (shift or insert), one registered read port.
    // A shift step reads the entry below the pointer; that entry is written
    // one place up in the following cycle, from the read register.
    always_ff @(posedge clk)
    begin
        if (cmd.probe)
            rd_reg <= mem[mid[AW-1:0]];
        else if (cmd.shift)
            rd_reg <= mem[AW'(ptr_reg - 1'b1)];
        if (cmd.write)
            mem[lo_reg[AW-1:0]] <= {id_reg, part_reg, dt_reg, db_reg};
        else if (shift_pend_reg)
            mem[AW'(ptr_reg + 1'b1)] <= rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            id_reg <= button_id;
            part_reg <= part;
            rlo_reg <= range_low;
            rhi_reg <= range_high;
            cap_reg <= cap_present;
            clo_reg <= cap_low;
            chi_reg <= cap_high;
            dt_reg <= (action == ACT_CLASSIFY) ? dest_type : 8'd0;
            db_reg <= (action == ACT_CLASSIFY) ? dest_button : 16'd0;
        end
        if (cmd.classify)
        begin
            bad_reg <= 1'b0;
            if (act_reg == ACT_CLASSIFY)
            begin
                part_reg <= cls[3] ? cls[2:0] : PART_NONE;
                bad_reg <= !cls[3];
            end
        end
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
            hit_reg <= 1'b0;
            ptr_reg <= count_reg;
        end
        if (cmd.probe)
            ptr_reg <= mid;
        if (cmd.compare)
        begin
            if (key_lt)
                hi_reg <= ptr_reg;
            else if (key_gt)
                lo_reg <= CW'(ptr_reg + 1'b1);
            else
            begin
                hit_reg <= 1'b1;
                lo_reg <= ptr_reg;
                dt_reg <= rd_reg[23:16];
                db_reg <= rd_reg[15:0];
            end
        end
        if (stat.srch_done && !cmd.probe && !cmd.compare && !cmd.shift && !cmd.write
            && !cmd.emit && !cmd.srch_init && !cmd.load)
            ptr_reg <= count_reg;
        if (cmd.shift)
            ptr_reg <= CW'(ptr_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done <= 1'b0;
            shift_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
                count_reg <= CW'(count_reg + 1'b1);
            done <= cmd.emit;
            shift_pend_reg <= cmd.shift;
        end
    end

    // Set at search start and cleared by a shift or write, so it marks that no insertion ran.
    always_ff @(posedge clk)
    begin
        if (cmd.srch_init)
            no_insert_reg <= 1'b1;
        else if (cmd.shift || cmd.write)
            no_insert_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            resolved_part <= part_reg;
            position <= bad_reg ? 7'd0 : 7'(lo_reg);
            found <= !bad_reg && hit_reg;
            if (bad_reg)
                status <= ST_BADRNG;
            else if (hit_reg)
                status <= do_ins ? ST_MISS : ST_OK;
            else if (!do_ins)
                status <= ST_MISS;
            else
                status <= ST_OK;
            out_dest_type <= dt_reg;
            out_dest_button <= db_reg;
            if (!bad_reg && !hit_reg && (!do_ins || no_insert_reg))
            begin
                out_dest_type <= 8'd0;
                out_dest_button <= 16'd0;
                if (do_ins)
                    status <= ST_FULL;
            end
            if (bad_reg)
            begin
                out_dest_type <= 8'd0;
                out_dest_button <= 16'd0;
            end
        end
    end

    `include "sorted_binding_table_top_assert.svh"
    `SBT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_ENTRIES))
    `SBT_ASSERT_IMPL(a_no_write_full, clk, rst_n, cmd.write, !stat.full)
    `SBT_ASSERT_NEXT(a_write_bumps, clk, rst_n, cmd.write, count_reg == $past(count_reg) + 1'b1)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted binding table testbench
// Directed table plus random add, classify and lookup transactions. Each
// result transaction is compared with a local model of the sorted table.
// ----------------------------------------------------------------------------
module testbench;
    import sbt_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_SPARE  = 2'd3;
    localparam int RANDOM_ITEMS = 1880;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] bid;
        logic [2:0]         prt;
        logic signed [31:0] rlo;
        logic signed [31:0] rhi;
        logic               cap;
        logic signed [31:0] clo;
        logic signed [31:0] chi;
        logic [7:0]         dtype;
        logic [15:0]        dbtn;
    } command_t;

    typedef struct {
        logic [1:0]  st;
        logic        fnd;
        logic [6:0]  pos;
        logic [2:0]  rpart;
        logic [7:0]  dtype;
        logic [15:0] dbtn;
    } reply_t;

    // One row of the directed table. A row with has_fixed set also carries
    // the reply typed in by hand, checked on top of the model prediction.
    typedef struct {
        command_t cmd;
        logic     has_fixed;
        reply_t   fixed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] action = '0;
    logic signed [31:0] button_id = '0;
    logic [2:0] part = '0;
    logic signed [31:0] range_low = '0;
    logic signed [31:0] range_high = '0;
    logic cap_present = 1'b0;
    logic signed [31:0] cap_low = '0;
    logic signed [31:0] cap_high = '0;
    logic [7:0] dest_type = '0;
    logic [15:0] dest_button = '0;
    wire busy, done, found;
    wire [1:0] status;
    wire [6:0] position;
    wire [2:0] resolved_part;
    wire [7:0] out_dest_type;
    wire [15:0] out_dest_button;

    sorted_binding_table_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .button_id(button_id), .part(part),
        .range_low(range_low), .range_high(range_high),
        .cap_present(cap_present), .cap_low(cap_low), .cap_high(cap_high),
        .dest_type(dest_type), .dest_button(dest_button),
        .done(done), .status(status), .found(found), .position(position),
        .resolved_part(resolved_part), .out_dest_type(out_dest_type),
        .out_dest_button(out_dest_button)
    );

    always #5 clk = ~clk;

    // Model of the table contents, kept in key order.
    logic signed [31:0] tbl_id [DEPTH];
    logic [2:0]         tbl_part [DEPTH];
    logic [7:0]         tbl_dtype [DEPTH];
    logic [15:0]        tbl_dbtn [DEPTH];
    int                 tbl_count;

    reply_t pending_replies[$];
    reply_t fixed_replies[$];
    logic   fixed_flags[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 18;

    // Part classification from the source and capability ranges, exact in
    // 64-bit arithmetic. Returns 0 in bit 3 when the range cannot be used.
    function automatic logic [3:0] part_from_range(command_t c);
        longint l, h, cl, ch, half;
        l = c.rlo; h = c.rhi; cl = c.clo; ch = c.chi;
        half = (ch >= 0) ? ch / 2 : -((-ch + 1) / 2);
        if (l > h) return {1'b1, PART_HAT_N};
        if (!c.cap) return {1'b1, PART_BUTTON};
        if (cl == 0 && (ch == 1 || ch == 2 ||
            (l < half && l != -64'sd2147483648 && cl + 7 != ch)))
            return {1'b1, PART_BUTTON};
        if (cl == ch - 7) begin
            if (l == cl + 1) return {1'b1, PART_HAT_E};
            if (l == cl + 3) return {1'b1, PART_HAT_S};
            if (l == cl + 5) return {1'b1, PART_HAT_W};
            return {1'b1, PART_NONE};
        end
        if (l == -64'sd2147483648) return {1'b1, PART_AXIS_LOW};
        if (h == 64'sd2147483647) return {1'b1, PART_AXIS_HIGH};
        return {1'b0, PART_NONE};
    endfunction

    // Applies one command to the table model and returns its reply.
    function automatic reply_t apply_binding(command_t c);
        reply_t r;
        logic [3:0] cls;
        logic [2:0] p;
        logic [7:0] dt;
        logic [15:0] db;
        int lo, hi, mid;
        logic hit;
        r = '{ST_OK, 1'b0, 7'd0, PART_NONE, 8'd0, 16'd0};
        p = c.prt; dt = '0; db = '0;
        if (c.act == ACT_CLASSIFY) begin
            cls = part_from_range(c);
            if (!cls[3]) begin
                r.st = ST_BADRNG;
                return r;
            end
            p = cls[2:0]; dt = c.dtype; db = c.dbtn;
        end
        lo = 0; hi = tbl_count; hit = 1'b0;
        while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (c.bid < tbl_id[mid]) hi = mid;
            else if (c.bid > tbl_id[mid]) lo = mid + 1;
            else if (p < tbl_part[mid]) hi = mid;
            else if (p > tbl_part[mid]) lo = mid + 1;
            else begin
                hit = 1'b1;
                lo = mid;
            end
        end
        r.fnd = hit; r.pos = lo[6:0]; r.rpart = p;
        if (hit) begin
            r.dtype = tbl_dtype[lo]; r.dbtn = tbl_dbtn[lo];
            r.st = (c.act >= ACT_LOOKUP) ? ST_OK : ST_MISS;
        end else if (c.act >= ACT_LOOKUP) begin
            r.st = ST_MISS;
        end else if (tbl_count >= DEPTH) begin
            r.st = ST_FULL;
        end else begin
            for (int i = tbl_count; i > lo; i--) begin
                tbl_id[i] = tbl_id[i-1]; tbl_part[i] = tbl_part[i-1];
                tbl_dtype[i] = tbl_dtype[i-1]; tbl_dbtn[i] = tbl_dbtn[i-1];
            end
            tbl_id[lo] = c.bid; tbl_part[lo] = p;
            tbl_dtype[lo] = dt; tbl_dbtn[lo] = db;
            tbl_count++;
            r.dtype = dt; r.dbtn = db;
        end
        return r;
    endfunction

    // Sends one transaction: waits for the block to be free, holds start for
    // the accepting edge and records the expected reply.
    task automatic send_binding(command_t c, logic has_fixed, reply_t fx);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b1;
        action <= c.act; button_id <= c.bid; part <= c.prt;
        range_low <= c.rlo; range_high <= c.rhi; cap_present <= c.cap;
        cap_low <= c.clo; cap_high <= c.chi;
        dest_type <= c.dtype; dest_button <= c.dbtn;
        pending_replies.push_back(apply_binding(c));
        fixed_replies.push_back(fx);
        fixed_flags.push_back(has_fixed);
        @(posedge clk);
        start <= 1'b0;
        // busy rises at the accepting edge itself; waiting here as well keeps the
        // next transaction from being taken as accepted too early.
        @(posedge clk);
    endtask

    task automatic drain_replies();
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    // Result checking: done marks a transaction for exactly one cycle.
    always @(posedge clk) begin
        reply_t e, fx;
        logic hf;
        if (rst_n && done) begin
            if (pending_replies.size() == 0) begin
                $error("result transaction with no expectation waiting");
                errors++;
            end else begin
                e = pending_replies.pop_front();
                fx = fixed_replies.pop_front();
                hf = fixed_flags.pop_front();
                if (hf && fx != e) begin
                    $error("table row disagrees with model status %0d/%0d",
                           fx.st, e.st);
                    errors++;
                end
                if (status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
                if (found !== e.fnd) begin
                    $error("found expected %0d actual %0d", e.fnd, found);
                    errors++;
                end
                if (position !== e.pos) begin
                    $error("position expected %0d actual %0d", e.pos, position);
                    errors++;
                end
                if (resolved_part !== e.rpart) begin
                    $error("resolved_part expected %0d actual %0d",
                           e.rpart, resolved_part);
                    errors++;
                end
                if (out_dest_type !== e.dtype) begin
                    $error("out_dest_type expected %0d actual %0d",
                           e.dtype, out_dest_type);
                    errors++;
                end
                if (out_dest_button !== e.dbtn) begin
                    $error("out_dest_button expected %0d actual %0d",
                           e.dbtn, out_dest_button);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(15)) - 32'd8);
            default: return $signed($urandom());
        endcase
    endfunction

    // Random command. Ids come from a small pool so duplicates and hits are
    // common; classify commands are mostly shaped to hit each class.
    function automatic command_t rand_command(int id_span);
        command_t c;
        int base;
        c.act = 2'($urandom_range(3));
        if ($urandom_range(9) == 0) c.bid = rand_word();
        else c.bid = $signed(32'($urandom_range(id_span)) - 32'(id_span / 2));
        c.prt = 3'($urandom_range(7));
        c.rlo = rand_word(); c.rhi = rand_word();
        c.cap = 1'($urandom_range(1));
        c.clo = rand_word(); c.chi = rand_word();
        c.dtype = 8'($urandom()); c.dbtn = 16'($urandom());
        case ($urandom_range(5))
            0: begin
                base = $urandom_range(40) - 20;
                c.clo = base; c.chi = base + 7;
                c.rlo = base + 2 * $urandom_range(3) - 1 + $urandom_range(1);
                c.rhi = c.rlo + $urandom_range(2);
            end
            1: begin
                c.clo = 0; c.chi = $urandom_range(300);
                c.rlo = $urandom_range(200); c.rhi = c.rlo + $urandom_range(100);
            end
            2: begin
                c.rlo = 32'sh8000_0000;
                if ($urandom_range(1)) c.clo = 0;
            end
            3: c.rhi = 32'sh7fff_ffff;
            default: ;
        endcase
        return c;
    endfunction

    localparam command_t Z = '{ACT_ADD, 0, PART_NONE, 0, 0, 0, 0, 0, 0, 0};

    initial begin
        row_t rows[$];
        row_t rw;
        command_t c;
        reply_t nofx;
        nofx = '{ST_OK, 1'b0, 7'd0, PART_NONE, 8'd0, 16'd0};
        tbl_count = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, each operation and each special case.
        rw.has_fixed = 1'b1;
        rw.cmd = Z; rw.cmd.act = ACT_LOOKUP;             // miss on empty table
        rw.fixed = '{ST_MISS, 1'b0, 7'd0, PART_NONE, 8'd0, 16'd0}; rows.push_back(rw);
        rw.cmd = Z; rw.cmd.bid = 32'sh7fff_ffff; rw.cmd.prt = PART_HAT_W;
        rw.fixed = '{ST_OK, 1'b0, 7'd0, PART_HAT_W, 8'd0, 16'd0}; rows.push_back(rw);
        rw.cmd = Z; rw.cmd.bid = 32'sh8000_0000;
        rw.fixed = '{ST_OK, 1'b0, 7'd0, PART_NONE, 8'd0, 16'd0}; rows.push_back(rw);
        rw.cmd = Z; rw.cmd.bid = 32'sh8000_0000;         // duplicate key
        rw.fixed = '{ST_MISS, 1'b1, 7'd0, PART_NONE, 8'd0, 16'd0}; rows.push_back(rw);
        rw.cmd = Z; rw.cmd.act = ACT_CLASSIFY; rw.cmd.cap = 1; rw.cmd.clo = 5;
        rw.cmd.chi = 100; rw.cmd.rlo = 10; rw.cmd.rhi = 20;  // unclassifiable
        rw.fixed = '{ST_BADRNG, 1'b0, 7'd0, PART_NONE, 8'd0, 16'd0}; rows.push_back(rw);
        rw.has_fixed = 1'b0;
        rw.cmd = Z; rw.cmd.act = ACT_CLASSIFY; rw.cmd.rlo = 5; rw.cmd.rhi = 1;
        rw.cmd.dtype = 8'hff; rw.cmd.dbtn = 16'hffff; rows.push_back(rw); // hat N
        rw.cmd = Z; rw.cmd.act = ACT_CLASSIFY; rw.cmd.bid = 3;
        rw.cmd.dtype = 8'h5a; rows.push_back(rw);        // no capability
        rw.cmd.cap = 1; rw.cmd.chi = 1; rows.push_back(rw);
        rw.cmd.chi = 2; rw.cmd.bid = 4; rows.push_back(rw);
        for (int k = 0; k < 4; k++) begin                 // hat E, S, W, none
            rw.cmd = Z; rw.cmd.act = ACT_CLASSIFY; rw.cmd.bid = 9; rw.cmd.cap = 1;
            rw.cmd.clo = -3; rw.cmd.chi = 4; rw.cmd.rlo = -2 + 2 * k;
            rw.cmd.rhi = 10; rw.cmd.dbtn = 16'(k + 1); rows.push_back(rw);
        end
        rw.cmd = Z; rw.cmd.act = ACT_CLASSIFY; rw.cmd.bid = 9; rw.cmd.cap = 1;
        rw.cmd.clo = 0; rw.cmd.chi = 7; rw.cmd.rlo = 1; rw.cmd.rhi = 2;
        rows.push_back(rw);                               // hat E on 0..7
        rw.cmd.clo = 100; rw.cmd.chi = 200; rw.cmd.rlo = 32'sh8000_0000;
        rows.push_back(rw);                               // axis low
        rw.cmd.rlo = 150; rw.cmd.rhi = 32'sh7fff_ffff; rows.push_back(rw);
        rw.cmd = Z; rw.cmd.act = ACT_LOOKUP; rw.cmd.bid = 9;
        rw.cmd.prt = PART_HAT_S; rows.push_back(rw);
        rw.cmd.act = ACT_SPARE; rw.cmd.prt = PART_AXIS_HIGH; rows.push_back(rw);
        rw.cmd.act = ACT_SPARE; rw.cmd.bid = 32'sh7fff_ffff;
        rw.cmd.prt = PART_HAT_W; rows.push_back(rw);

        send_idle_pct = 0;
        foreach (rows[i]) send_binding(rows[i].cmd, rows[i].has_fixed, rows[i].fixed);
        drain_replies();

        // Random part in three idling phases. Every few hundred the table is
        // filled to the top, so full refusals are reached with varied keys.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_idle_pct = (n < RANDOM_ITEMS / 3) ? 18 :
                            (n < 2 * RANDOM_ITEMS / 3) ? 63 : 0;
            c = rand_command((n % 400 < 200) ? 40 : 4000);
            if (n % 400 >= 200 && $urandom_range(1)) c.act = ACT_ADD;
            send_binding(c, 1'b0, nofx);
            if (n == RANDOM_ITEMS / 2) drain_replies();
        end

        drain_replies();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_replies.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
